### src/mrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg: modem response checker shared definitions
// Item layouts, command/status codes, register indexes and the CRC-16/ARC
// byte update used by the response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

  // Item kinds on the input channel
  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_RX_BYTE = 3'd1;
  localparam logic [2:0] KIND_TX_DONE = 3'd2;
  localparam logic [2:0] KIND_TICK    = 3'd3;
  localparam logic [2:0] KIND_READ    = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_SUCCESS = 2'd1;
  localparam logic [1:0] STAT_RESEND  = 2'd2;
  localparam logic [1:0] STAT_FAILED  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_EXP_CMD     = 2'd0;
  localparam logic [1:0] REG_EXP_LENGTH  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;
  localparam logic [1:0] REG_MAX_RETRIES = 2'd3;

  localparam int CFG_DATA_W = 32;

  // Register reset values (timeout is 30 s at 1000 ticks per second)
  localparam logic [7:0]  EXP_CMD_RST     = 8'd0;
  localparam logic [8:0]  EXP_LENGTH_RST  = 9'd5;
  localparam logic [31:0] TIMEOUT_RST     = 32'd30000;
  localparam logic [2:0]  MAX_RETRIES_RST = 3'd3;

  // Response framing
  localparam logic [7:0]  RESP_START = 8'h3e;
  localparam logic [7:0]  RESP_END   = 8'h3b;
  localparam logic [15:0] CRC_POLY   = 16'ha001;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } mrc_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       busy_res;
    logic [8:0] received_length;
    logic [7:0] read_data;
    logic [2:0] retries_used;
  } mrc_out_t;

  // One byte of reflected CRC-16/ARC
  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/mrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_in_if / mrc_out_if: valid/ready channels of the response checker
// Input channel carries request items, output channel carries result items.
// ----------------------------------------------------------------------------
interface mrc_in_if;
  import mrc_pkg::*;
  logic    valid;
  logic    ready;
  mrc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrc_out_if;
  import mrc_pkg::*;
  logic     valid;
  logic     ready;
  mrc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/modem_response_checker_retry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_response_checker_retry: receive side of a modem transaction
// Captures the response frame, checks framing, echo, length and CRC-16/ARC
// on a tick, and asks for resends up to a retry limit.
// ----------------------------------------------------------------------------
// Pipeline: the state update plus buffer read register on item accept, then
//   the output register that presents the result.
// Throughput: one item per cycle; the input stalls only while the output
//   register holds a result that has not been taken.
// Reset: synchronous, clears transaction state and loads register defaults;
//   the response buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module modem_response_checker_retry #(
  parameter int RX_BUF_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  mrc_in_if.sink                        in_ch,
  mrc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mrc_pkg::*;

  localparam int AW = $clog2(RX_BUF_DEPTH);
  localparam int CW = $clog2(RX_BUF_DEPTH + 1);
  localparam int LW = (CW > 9) ? CW : 9;

  // Configuration registers
  logic [7:0]  expected_cmd;
  logic [8:0]  expected_length;
  logic [31:0] timeout_ticks;
  logic [2:0]  max_retries;

  // Transaction state
  logic [CW-1:0] byte_count, byte_count_next;
  logic          rx_done, rx_done_next;
  logic          tx_done, tx_done_next;
  logic          active, active_next;
  logic [2:0]    retry_count, retry_count_next;
  logic [31:0]   elapsed_ticks, elapsed_ticks_next;
  logic [15:0]   running_crc, running_crc_next;
  logic [23:0]   crc_lag_bytes, crc_lag_bytes_next;
  logic [7:0]    echo_byte, echo_byte_next;

  // Buffer
  logic [7:0]    response_buffer [RX_BUF_DEPTH];
  logic          mem_we;
  logic [AW-1:0] raddr;
  logic [7:0]    rd_q;

  // Pipeline
  logic     acc;
  logic     s1_valid, s1_adv, s1_rd_en;
  logic     rd_en;
  mrc_out_t s1_res;
  mrc_out_t out_next;
  logic [1:0] status;
  logic       restart, retry, finish, resp_ok;
  logic [31:0] el_inc;
  logic [CW-1:0] cnt_inc;
  logic          take_ok;

  assign s1_adv      = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign acc         = in_ch.valid && in_ch.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_cmd    <= EXP_CMD_RST;
      expected_length <= EXP_LENGTH_RST;
      timeout_ticks   <= TIMEOUT_RST;
      max_retries     <= MAX_RETRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXP_CMD:     expected_cmd    <= cfg_data[7:0];
        REG_EXP_LENGTH:  expected_length <= cfg_data[8:0];
        REG_TIMEOUT:     timeout_ticks   <= cfg_data[31:0];
        REG_MAX_RETRIES: max_retries     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Response check: last three stored bytes sit in the lag register
  always_comb begin
    resp_ok = (expected_length == 9'd0) ||
              ((byte_count >= CW'(5)) &&
               (LW'(byte_count) == LW'(expected_length)) &&
               (crc_lag_bytes[7:0] == RESP_END) &&
               (echo_byte == expected_cmd) &&
               (crc_lag_bytes[23:8] == running_crc));
  end

  assign el_inc  = (elapsed_ticks != '1) ? elapsed_ticks + 32'd1 : elapsed_ticks;
  assign cnt_inc = byte_count + CW'(1);
  assign take_ok = !((byte_count == '0) && (in_ch.data.rx_byte != RESP_START));

  // Next state for the accepted item
  always_comb begin
    byte_count_next    = byte_count;
    rx_done_next       = rx_done;
    tx_done_next       = tx_done;
    active_next        = active;
    retry_count_next   = retry_count;
    elapsed_ticks_next = elapsed_ticks;
    running_crc_next   = running_crc;
    crc_lag_bytes_next = crc_lag_bytes;
    echo_byte_next     = echo_byte;
    mem_we  = 1'b0;
    status  = STAT_NONE;
    restart = 1'b0;
    retry   = 1'b0;
    finish  = 1'b0;
    rd_en   = 1'b0;

    case (in_ch.data.kind)
      KIND_START: begin
        if (!active) begin
          active_next      = 1'b1;
          retry_count_next = 3'd0;
          restart          = 1'b1;
        end
      end
      KIND_RX_BYTE: begin
        if (active && !rx_done && take_ok) begin
          if (byte_count < CW'(RX_BUF_DEPTH)) begin
            mem_we = 1'b1;
            if (byte_count == CW'(1)) begin
              echo_byte_next = in_ch.data.rx_byte;
            end
            if (byte_count >= CW'(4)) begin
              running_crc_next = crc_arc_byte(running_crc, crc_lag_bytes[23:16]);
            end
            if (byte_count != '0) begin
              crc_lag_bytes_next = {crc_lag_bytes[15:0], in_ch.data.rx_byte};
            end
            byte_count_next = cnt_inc;
          end else begin
            finish = 1'b1;
          end
          if (LW'(byte_count_next) == LW'(expected_length)) begin
            finish = 1'b1;
          end
          if (finish) begin
            rx_done_next = 1'b1;
          end
        end
      end
      KIND_TX_DONE: begin
        if (active) begin
          tx_done_next = 1'b1;
        end
      end
      KIND_TICK: begin
        if (active) begin
          elapsed_ticks_next = el_inc;
          if (tx_done && rx_done) begin
            if (resp_ok) begin
              status      = STAT_SUCCESS;
              active_next = 1'b0;
            end else begin
              retry = 1'b1;
            end
          end else if (el_inc > timeout_ticks) begin
            retry = 1'b1;
          end
          if (retry) begin
            if (retry_count < max_retries) begin
              retry_count_next = retry_count + 3'd1;
              restart          = 1'b1;
              status           = STAT_RESEND;
            end else begin
              active_next = 1'b0;
              status      = STAT_FAILED;
            end
          end
        end
      end
      KIND_READ: begin
        rd_en = (int'(in_ch.data.read_index) < RX_BUF_DEPTH);
      end
      default: ;
    endcase

    // New attempt: clear reception and transmit progress
    if (restart) begin
      elapsed_ticks_next = 32'd0;
      tx_done_next       = 1'b0;
      byte_count_next    = '0;
      running_crc_next   = 16'd0;
      crc_lag_bytes_next = 24'd0;
      echo_byte_next     = 8'd0;
      rx_done_next       = (expected_length == 9'd0);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      rx_done       <= 1'b0;
      tx_done       <= 1'b0;
      active        <= 1'b0;
      retry_count   <= 3'd0;
      elapsed_ticks <= 32'd0;
      running_crc   <= 16'd0;
      crc_lag_bytes <= 24'd0;
      echo_byte     <= 8'd0;
    end else if (acc) begin
      byte_count    <= byte_count_next;
      rx_done       <= rx_done_next;
      tx_done       <= tx_done_next;
      active        <= active_next;
      retry_count   <= retry_count_next;
      elapsed_ticks <= elapsed_ticks_next;
      running_crc   <= running_crc_next;
      crc_lag_bytes <= crc_lag_bytes_next;
      echo_byte     <= echo_byte_next;
    end
  end

  // Response buffer: write on stored byte, registered read on accept
  assign raddr = AW'(in_ch.data.read_index);

  always_ff @(posedge clk) begin
    if (acc && mem_we) begin
      response_buffer[byte_count[AW-1:0]] <= in_ch.data.rx_byte;
    end
    if (acc) begin
      rd_q <= response_buffer[raddr];
    end
  end

  // Stage one: result fields after the state update
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res.status          <= status;
      s1_res.busy_res        <= active_next;
      s1_res.received_length <= 9'(byte_count_next);
      s1_res.read_data       <= 8'd0;
      s1_res.retries_used    <= retry_count_next;
      s1_rd_en               <= rd_en;
    end
  end

  // Read data joins the stage one fields on the way out
  always_comb begin
    out_next           = s1_res;
    out_next.read_data = s1_rd_en ? rd_q : 8'd0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (s1_adv) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch.data <= out_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(RX_BUF_DEPTH))
    else $error("byte count beyond buffer depth");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_res))
    else $error("stage one item lost while stalled");

  a_status_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.data.status != STAT_NONE) |->
      (out_ch.data.busy_res == (out_ch.data.status == STAT_RESEND)))
    else $error("status and busy flag disagree");

  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    acc && (status == STAT_RESEND) |=> (byte_count == '0) && !tx_done)
    else $error("resend did not clear the attempt");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: modem response checker with resend
// Drives start, byte, transmit-done, tick and buffer-read items through the
// input channel with bursty gaps, takes results under a varying stall
// pattern, and checks each result against a cycle-free shadow of the
// checker state: frame capture, CRC-16/ARC, timeout and retry accounting.
// ----------------------------------------------------------------------------
module tb;
  import mrc_pkg::*;

  localparam int BUF_DEPTH   = 256;
  localparam int ITEM_GOAL   = 850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 80;
  localparam int DUT_LATENCY = 4;

  // Kinds outside the defined set; the block must leave them alone
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef enum {FLAW_NONE, FLAW_CRC, FLAW_END, FLAW_ECHO, FLAW_SHORT} frame_flaw_t;
  typedef enum {PACE_FULL, PACE_COIN, PACE_TRICKLE} rx_pace_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_EXP_CMD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mrc_in_if  in_ch ();
  mrc_out_if out_ch ();

  modem_response_checker_retry dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the checker state
  logic [7:0]  rsp_mem [BUF_DEPTH];
  int          rsp_fill = 0;        // entries below this index have been written
  logic [8:0]  rx_count = '0;
  bit          rx_complete = 1'b0;
  bit          tx_complete = 1'b0;
  bit          txn_open = 1'b0;
  logic [2:0]  resend_count = '0;
  logic [31:0] tick_count = '0;
  logic [15:0] crc_acc = '0;
  logic [23:0] crc_delay = '0;
  logic [7:0]  echo_cmd = '0;

  // Shadow of the registers, reset values
  logic [7:0]  exp_cmd = EXP_CMD_RST;
  logic [8:0]  exp_len = EXP_LENGTH_RST;
  logic [31:0] tick_limit = TIMEOUT_RST;
  logic [2:0]  resend_limit = MAX_RETRIES_RST;

  mrc_in_t  pending_items [$];
  mrc_out_t expected_results [$];
  int       effective_items = 0;
  int       mismatches = 0;

  // Sender burst state
  int burst_left = 0;
  int gap_left = 0;

  // Receiver pacing state
  bit       hold_req = 1'b0;
  bit       hold_ack = 1'b0;
  int       hold_left = 0;
  rx_pace_t rx_pace = PACE_FULL;
  int       pace_left = 0;
  int       pace_phase = 0;

  // Reflected CRC-16/ARC, one byte
  function automatic logic [15:0] crc16_arc(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ 16'ha001) : (c >> 1);
    return c;
  endfunction

  function automatic void begin_attempt();
    tick_count  = '0;
    tx_complete = 1'b0;
    rx_count    = '0;
    crc_acc     = '0;
    crc_delay   = '0;
    echo_cmd    = '0;
    rx_complete = (exp_len == 0);
  endfunction

  // Capture one byte; the CRC trails the stored bytes by three
  function automatic void store_rx_byte(input logic [7:0] b);
    bit done;
    done = 1'b0;
    if (rx_count == 0 && b != RESP_START) begin
      return;
    end
    if (rx_count < BUF_DEPTH) begin
      rsp_mem[rx_count] = b;
      if (rx_count == 1) echo_cmd = b;
      if (rx_count >= 4) crc_acc = crc16_arc(crc_acc, crc_delay[23:16]);
      if (rx_count >= 1) crc_delay = {crc_delay[15:0], b};
      rx_count = rx_count + 1;
      if (rx_count > rsp_fill) rsp_fill = rx_count;
    end else begin
      // buffer full: byte dropped, reception closed
      done = 1'b1;
    end
    if (rx_count == exp_len) done = 1'b1;
    if (done) rx_complete = 1'b1;
  endfunction

  function automatic bit response_valid();
    int n;
    logic [15:0] got;
    n = rx_count;
    if (exp_len == 0) return 1'b1;
    if (n < 5 || n != exp_len || n > BUF_DEPTH) return 1'b0;
    if (rsp_mem[0] != RESP_START || rsp_mem[n-1] != RESP_END) return 1'b0;
    if (echo_cmd != exp_cmd) return 1'b0;
    got = {rsp_mem[n-3], rsp_mem[n-2]};
    return got == crc_acc;
  endfunction

  // Advance the shadow by one item and return the result it should give
  function automatic mrc_out_t predict_result(input mrc_in_t it, output bit effective);
    mrc_out_t r;
    bit resend;
    r = '0;
    effective = 1'b0;
    resend = 1'b0;
    case (it.kind)
      KIND_START: begin
        if (!txn_open) begin
          txn_open = 1'b1;
          resend_count = '0;
          begin_attempt();
          effective = 1'b1;
        end
      end
      KIND_RX_BYTE: begin
        if (txn_open && !rx_complete) begin
          store_rx_byte(it.rx_byte);
          effective = 1'b1;
        end
      end
      KIND_TX_DONE: begin
        if (txn_open) begin
          tx_complete = 1'b1;
          effective = 1'b1;
        end
      end
      KIND_TICK: begin
        if (txn_open) begin
          effective = 1'b1;
          if (tick_count != 32'hffff_ffff) tick_count++;
          if (tx_complete && rx_complete) begin
            if (response_valid()) begin
              r.status = STAT_SUCCESS;
              txn_open = 1'b0;
            end else begin
              resend = 1'b1;
            end
          end else if (tick_count > tick_limit) begin
            resend = 1'b1;
          end
          if (resend) begin
            if (resend_count < resend_limit) begin
              resend_count++;
              begin_attempt();
              r.status = STAT_RESEND;
            end else begin
              txn_open = 1'b0;
              r.status = STAT_FAILED;
            end
          end
        end
      end
      KIND_READ: begin
        r.read_data = rsp_mem[it.read_index];
        effective = 1'b1;
      end
      default: begin
      end
    endcase
    r.busy_res        = txn_open;
    r.received_length = rx_count;
    r.retries_used    = resend_count;
    return r;
  endfunction

  // Fields that the kind does not use carry noise
  function automatic void queue_item(input logic [2:0] kind, input logic [7:0] value);
    mrc_in_t it;
    it.kind       = kind;
    it.rx_byte    = (kind == KIND_RX_BYTE) ? value : 8'($urandom);
    it.read_index = (kind == KIND_READ) ? value : 8'($urandom);
    pending_items.push_back(it);
  endfunction

  // One response frame, optionally flawed, with ticks scattered in between
  function automatic void push_response(input int len, input logic [7:0] cmd,
                                        input frame_flaw_t flaw, input int tick_pct);
    logic [7:0]  frame [$];
    logic [15:0] crc;
    int keep;
    frame.push_back(RESP_START);
    if (len >= 5) begin
      frame.push_back(flaw == FLAW_ECHO ? cmd ^ (8'h01 << $urandom_range(0, 7)) : cmd);
      for (int i = 5; i < len; i++) frame.push_back(8'($urandom));
      crc = '0;
      for (int i = 1; i < frame.size(); i++) crc = crc16_arc(crc, frame[i]);
      if (flaw == FLAW_CRC) crc ^= 16'h0001 << $urandom_range(0, 15);
      frame.push_back(crc[15:8]);
      frame.push_back(crc[7:0]);
      frame.push_back(flaw == FLAW_END ? RESP_END ^ 8'($urandom_range(1, 255)) : RESP_END);
    end else begin
      for (int i = 1; i < len; i++) frame.push_back(8'($urandom));
    end
    keep = frame.size();
    if (flaw == FLAW_SHORT && keep > 1) keep = $urandom_range(1, keep - 1);
    for (int i = 0; i < keep; i++) begin
      if ($urandom_range(0, 99) < tick_pct) queue_item(KIND_TICK, 8'h00);
      queue_item(KIND_RX_BYTE, frame[i]);
    end
  endfunction

  // Start, then up to four attempts, ending at the first clean frame
  function automatic void queue_transaction(input int tick_pct);
    int attempts;
    frame_flaw_t flaw;
    bit tx_first;
    queue_item(KIND_START, 8'h00);
    if ($urandom_range(0, 7) == 0) queue_item(KIND_START, 8'h00);
    attempts = $urandom_range(1, 4);
    for (int a = 0; a < attempts; a++) begin
      flaw = ($urandom_range(0, 9) < 5) ? FLAW_NONE
                                         : frame_flaw_t'($urandom_range(FLAW_CRC, FLAW_SHORT));
      if (flaw == FLAW_SHORT && tick_limit > 64) flaw = FLAW_NONE;
      // stray bytes ahead of the start byte
      repeat ($urandom_range(0, 2)) begin
        queue_item(KIND_RX_BYTE, RESP_START ^ 8'($urandom_range(1, 255)));
      end
      tx_first = $urandom_range(0, 1);
      if (tx_first && flaw != FLAW_SHORT) queue_item(KIND_TX_DONE, 8'h00);
      push_response(exp_len, exp_cmd, flaw, tick_pct);
      if (flaw == FLAW_SHORT) begin
        // let the attempt run out of time
        repeat (tick_limit + 1) queue_item(KIND_TICK, 8'h00);
      end else begin
        if (!tx_first) queue_item(KIND_TX_DONE, 8'h00);
        queue_item(KIND_TICK, 8'h00);
      end
      if ($urandom_range(0, 3) == 0) queue_item(KIND_READ, 8'($urandom));
      if (flaw == FLAW_NONE) break;
    end
    if ($urandom_range(0, 9) == 0) begin
      queue_item(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 8'($urandom));
    end
  endfunction

  // Sender: predict on accept, then offer the next item or idle
  always @(posedge clk) begin
    mrc_in_t  nxt;
    mrc_out_t res;
    bit       eff;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        res = predict_result(in_ch.data, eff);
        expected_results.push_back(res);
        if (eff) effective_items++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          // reads only touch entries that hold a stored byte; the stimulus
          // never reads before the first frame has been captured
          if (nxt.kind == KIND_READ && nxt.read_index >= rsp_fill) begin
            nxt.read_index = 8'(nxt.read_index % rsp_fill);
          end
          in_ch.data  <= nxt;
          in_ch.valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: check each result, then pick the next ready value
  always @(posedge clk) begin
    mrc_out_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: %p", out_ch.data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.data.status);
            mismatches++;
          end
          if (out_ch.data.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, out_ch.data.busy_res);
            mismatches++;
          end
          if (out_ch.data.received_length !== want.received_length) begin
            $error("received_length: expected %0d, got %0d",
                   want.received_length, out_ch.data.received_length);
            mismatches++;
          end
          if (out_ch.data.read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, out_ch.data.read_data);
            mismatches++;
          end
          if (out_ch.data.retries_used !== want.retries_used) begin
            $error("retries_used: expected %0d, got %0d",
                   want.retries_used, out_ch.data.retries_used);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req != hold_ack) begin
        // long hold-off so the block backs up into its input
        hold_ack = hold_req;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        if (pace_left <= 0) begin
          rx_pace = rx_pace_t'($urandom_range(PACE_FULL, PACE_TRICKLE));
          pace_left = $urandom_range(8, 64);
        end
        pace_left--;
        pace_phase++;
        case (rx_pace)
          PACE_FULL: begin
            out_ch.ready <= 1'b1;
          end
          PACE_COIN: begin
            out_ch.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ch.ready <= (pace_phase % 4 == 0);
          end
        endcase
      end
    end
  end

  // Run limit
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Wait until every offered item has come back, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (DUT_LATENCY) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] cmd, input logic [8:0] len,
                            input logic [31:0] tmo, input logic [2:0] retries);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EXP_CMD;
    cfg_data  <= CFG_DATA_W'(cmd);
    @(posedge clk);
    cfg_index <= REG_EXP_LENGTH;
    cfg_data  <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_index <= REG_MAX_RETRIES;
    cfg_data  <= CFG_DATA_W'(retries);
    @(posedge clk);
    cfg_we <= 1'b0;
    exp_cmd      = cmd;
    exp_len      = len;
    tick_limit   = tmo;
    resend_limit = retries;
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int phase;
    int tick_pct;
    logic [7:0] cmd;
    logic [8:0] len;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, register defaults: idle items are ignored
    queue_item(KIND_TX_DONE, 8'h00);
    queue_item(KIND_TICK, 8'h00);
    queue_item(KIND_RX_BYTE, 8'hff);
    queue_item(KIND_SPARE_HI, 8'hff);
    // clean frame after a dropped byte, then late byte and start while active
    queue_item(KIND_START, 8'h00);
    queue_item(KIND_RX_BYTE, 8'h00);
    push_response(5, EXP_CMD_RST, FLAW_NONE, 0);
    queue_item(KIND_RX_BYTE, 8'h00);
    queue_item(KIND_START, 8'h00);
    queue_item(KIND_TX_DONE, 8'h00);
    queue_item(KIND_TICK, 8'h00);
    queue_item(KIND_READ, 8'h00);
    queue_item(KIND_READ, 8'h04);
    // bad CRC asks for a resend
    queue_item(KIND_START, 8'h00);
    push_response(5, EXP_CMD_RST, FLAW_CRC, 0);
    queue_item(KIND_TX_DONE, 8'h00);
    queue_item(KIND_TICK, 8'h00);
    drain();

    // Random phases; the first few pin the register extremes
    phase = 0;
    while (effective_items < ITEM_GOAL || phase < 4) begin
      cmd = 8'($urandom);
      tick_pct = $urandom_range(0, 8);
      case (phase)
        0: set_config(8'hff, 9'd0, 32'd1, 3'd0);
        1: set_config(8'h00, 9'd256, 32'hffff_ffff, 3'd7);
        2: set_config(cmd, 9'($urandom_range(1, 4)), 32'd3, 3'd2);
        3: set_config(cmd, 9'd10, 32'd1, 3'd0);
        default: begin
          case ($urandom_range(0, 15))
            0:       len = 9'd0;
            1, 2:    len = 9'($urandom_range(1, 4));
            13, 14:  len = 9'($urandom_range(13, 40));
            15:      len = 9'd5;
            default: len = 9'($urandom_range(5, 12));
          endcase
          set_config(cmd, len, 32'($urandom_range(8, 60)), 3'($urandom_range(0, 7)));
        end
      endcase

      if (phase == 1) begin
        // full-size frame while the receiver holds off for a long stretch
        hold_req = ~hold_req;
        queue_transaction(2);
        queue_item(KIND_READ, 8'hff);
        queue_item(KIND_READ, 8'h00);
        repeat (16) queue_item(KIND_READ, 8'($urandom));
      end else if (phase == 3) begin
        // close anything still open, then fill past a shortened length so
        // the buffer runs full and the overflow byte ends reception
        queue_item(KIND_TICK, 8'h00);
        queue_item(KIND_TICK, 8'h00);
        queue_item(KIND_START, 8'h00);
        queue_item(KIND_RX_BYTE, RESP_START);
        repeat (5) queue_item(KIND_RX_BYTE, 8'($urandom));
        drain();
        set_config(cmd, 9'd3, 32'd1, 3'd0);
        repeat (255) queue_item(KIND_RX_BYTE, 8'($urandom));
        queue_item(KIND_TX_DONE, 8'h00);
        queue_item(KIND_TICK, 8'h00);
        repeat (2) queue_transaction(0);
      end else begin
        repeat ($urandom_range(3, 8)) queue_transaction(phase == 0 ? 10 : tick_pct);
      end
      drain();
      phase++;
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
